// ----- src/suoc_pkg.sv -----
package suoc_pkg;

  // Default depth of the pattern store and the text window.
  localparam int MAX_PATTERN_DEF = 16;

  // Fixed field widths.
  localparam int CFG_W   = 5;
  localparam int POS_W   = 4;
  localparam int SYM_W   = 8;
  localparam int COUNT_W = 24;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Action codes on the input channel.
  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_TEXT  = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;

  // Depth of the command queue and of the result queue.
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Operation decided by the front end.
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_TEXT,
    OP_START,
    OP_NONE
  } op_t;

  // One command handed from the front end to the back end.
  typedef struct packed {
    op_t              op;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
    logic             last;
  } cmd_t;

  // Command channel between front and back end.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

  // One result item.
  typedef struct packed {
    logic               match_end;
    logic [COUNT_W-1:0] match_count;
    logic               text_done;
  } res_t;

endpackage

// ----- src/suoc_front.sv -----
module suoc_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                action,
  input  logic [suoc_pkg::POS_W-1:0] position,
  input  logic [suoc_pkg::SYM_W-1:0] symbol,
  input  logic                      last,
  output suoc_pkg::cmd_chan_t       chan,
  input  logic                      take
);

  suoc_pkg::cmd_t                     mem [suoc_pkg::Q_DEPTH];
  logic [suoc_pkg::Q_PTR_W-1:0]       wr_ptr;
  logic [suoc_pkg::Q_PTR_W-1:0]       rd_ptr;
  logic [suoc_pkg::Q_CNT_W-1:0]       count;
  suoc_pkg::cmd_t                     decoded;
  logic                               do_push;
  logic                               do_pop;

  // Classify the incoming item.
  always_comb begin
    decoded.position = position;
    decoded.symbol   = symbol;
    decoded.last     = last;
    case (action)
      suoc_pkg::ACT_LOAD:  decoded.op = suoc_pkg::OP_LOAD;
      suoc_pkg::ACT_TEXT:  decoded.op = suoc_pkg::OP_TEXT;
      suoc_pkg::ACT_START: decoded.op = suoc_pkg::OP_START;
      default:             decoded.op = suoc_pkg::OP_NONE;
    endcase
  end

  assign full       = (count == suoc_pkg::Q_CNT_W'(suoc_pkg::Q_DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = take && (count != '0);
  assign chan.valid = (count != '0);
  assign chan.cmd   = mem[rd_ptr];

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/suoc_back.sv -----
module suoc_back #(
  parameter int MAX_PATTERN = suoc_pkg::MAX_PATTERN_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [suoc_pkg::CFG_W-1:0] cfg_data,
  input  suoc_pkg::cmd_chan_t        chan,
  output logic                       take,
  input  logic                       res_full,
  output logic                       res_push,
  output suoc_pkg::res_t             res_data
);

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CW    = (LEN_W > suoc_pkg::CFG_W) ? LEN_W : suoc_pkg::CFG_W;

  logic [suoc_pkg::SYM_W-1:0]   pattern    [MAX_PATTERN];
  logic [suoc_pkg::SYM_W-1:0]   window     [MAX_PATTERN];
  logic [suoc_pkg::SYM_W-1:0]   window_new [MAX_PATTERN];
  logic [suoc_pkg::CFG_W-1:0]   pattern_length;
  logic [LEN_W-1:0]             fill;
  logic [LEN_W-1:0]             fill_next;
  logic [suoc_pkg::COUNT_W-1:0] count;
  logic [suoc_pkg::COUNT_W-1:0] count_next;
  logic [LEN_W-1:0]             eff_len;
  logic [CW-1:0]                cfg_ext;
  logic [CW-1:0]                max_ext;
  logic                         all_eq;
  logic                         hit;
  logic                         is_text;

  assign take     = chan.valid && !res_full;
  assign res_push = take;
  assign is_text  = (chan.cmd.op == suoc_pkg::OP_TEXT);

  // Length in use: zero counts as one, anything above the store depth is clamped.
  assign cfg_ext = CW'(pattern_length);
  assign max_ext = CW'(MAX_PATTERN);
  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_ext > max_ext) begin
      eff_len = LEN_W'(MAX_PATTERN);
    end else begin
      eff_len = LEN_W'(cfg_ext);
    end
  end

  // Window as it stands after the new character shifts in.
  always_comb begin
    window_new[0] = chan.cmd.symbol;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      window_new[j] = window[j-1];
    end
  end

  // Parallel compare of the newest characters against the pattern.
  always_comb begin
    logic [LEN_W-1:0] idx;
    all_eq = 1'b1;
    idx    = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      idx = eff_len - LEN_W'(1) - LEN_W'(k);
      if (LEN_W'(k) < eff_len) begin
        if (pattern[k] != window_new[idx[IDX_W-1:0]]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign fill_next = (fill == LEN_W'(MAX_PATTERN)) ? fill : fill + 1'b1;
  assign hit       = is_text && (fill_next >= eff_len) && all_eq;

  // Saturating occurrence count.
  always_comb begin
    count_next = count;
    if (chan.cmd.op == suoc_pkg::OP_START) begin
      count_next = '0;
    end else if (hit && (count != suoc_pkg::COUNT_MAX)) begin
      count_next = count + 1'b1;
    end
  end

  // Result of the command being carried out.
  assign res_data.match_end   = hit;
  assign res_data.match_count = count_next;
  assign res_data.text_done   = is_text && chan.cmd.last;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= suoc_pkg::CFG_W'(1);
    end else if (cfg_write) begin
      pattern_length <= cfg_data;
    end
  end

  // Pattern store and text window; entries beyond the pattern length in use are never compared.
  always_ff @(posedge clk) begin
    if (take && chan.cmd.op == suoc_pkg::OP_LOAD &&
        ({28'd0, chan.cmd.position} < 32'(MAX_PATTERN))) begin
      pattern[IDX_W'(chan.cmd.position)] <= chan.cmd.symbol;
    end
    if (take && is_text) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        window[j] <= window_new[j];
      end
    end
  end

  // Fill level and count; a final character or a start item clears both.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill  <= '0;
      count <= '0;
    end else if (take) begin
      if (chan.cmd.op == suoc_pkg::OP_START || (is_text && chan.cmd.last)) begin
        fill  <= '0;
        count <= '0;
      end else if (is_text) begin
        fill  <= fill_next;
        count <= count_next;
      end
    end
  end

endmodule

// ----- src/suoc_resq.sv -----
module suoc_resq (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_push,
  input  suoc_pkg::res_t res_data,
  output logic           res_full,
  output logic           empty,
  input  logic           pop,
  output suoc_pkg::res_t head
);

  suoc_pkg::res_t               mem [suoc_pkg::Q_DEPTH];
  logic [suoc_pkg::Q_PTR_W-1:0] wr_ptr;
  logic [suoc_pkg::Q_PTR_W-1:0] rd_ptr;
  logic [suoc_pkg::Q_CNT_W-1:0] count;
  logic                         do_push;
  logic                         do_pop;

  assign res_full = (count == suoc_pkg::Q_CNT_W'(suoc_pkg::Q_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign head     = mem[rd_ptr];

  // Result storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= res_data;
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/substring_occurrence_counter.sv -----
// Channel   Handshake             Payload
// input     push / full           action, position, symbol, last
// result    empty / pop           match_end, match_count, text_done
// config    cfg_write             cfg_data (pattern length)
//
// One item is accepted every cycle while full is low; items and results are registered
// in the queues. The rate is set by the back end, which shifts the window and compares
// it against the whole pattern combinationally; two-entry queues sit on either side.
// Reset is synchronous; no clearing pass is needed, the block is ready right after it.
// A stalled result side fills the result queue, then the command queue, then raises full.
module substring_occurrence_counter #(
  parameter int MAX_PATTERN = suoc_pkg::MAX_PATTERN_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   action,
  input  logic [suoc_pkg::POS_W-1:0]   position,
  input  logic [suoc_pkg::SYM_W-1:0]   symbol,
  input  logic                         last,
  output logic                         empty,
  input  logic                         pop,
  output logic                         match_end,
  output logic [suoc_pkg::COUNT_W-1:0] match_count,
  output logic                         text_done,
  input  logic                         cfg_write,
  input  logic [suoc_pkg::CFG_W-1:0]   cfg_data
);

  suoc_pkg::cmd_chan_t chan;
  suoc_pkg::res_t      res_data;
  suoc_pkg::res_t      head;
  logic                take;
  logic                res_full;
  logic                res_push;

  // Front end: decode and queue commands.
  suoc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .action   (action),
    .position (position),
    .symbol   (symbol),
    .last     (last),
    .chan     (chan),
    .take     (take)
  );

  // Back end: pattern store, window compare and count.
  suoc_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .chan      (chan),
    .take      (take),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  // Result queue toward the consumer.
  suoc_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  assign match_end   = head.match_end;
  assign match_count = head.match_count;
  assign text_done   = head.text_done;

  // The back end only takes a command that is present.
  a_take_valid : assert property (@(posedge clk) disable iff (rst)
    take |-> chan.valid)
    else $error("back end took a command from an empty queue");

  // A result is never pushed into a full result queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed while the result queue is full");

  // After a final character the count starts over.
  a_count_restart : assert property (@(posedge clk) disable iff (rst)
    (res_push && res_data.text_done) |=>
      (!res_push || res_data.match_count <= suoc_pkg::COUNT_W'(1)))
    else $error("count not cleared after the end of a text");

endmodule
